@@ rtl/core/sapr_pkg.sv @@
// Package: sizes, codes and helpers for the ping-pong audio resampler.
package sapr_pkg;

  // Frame geometry
  localparam int unsigned FRAME_SAMPLES = 262;
  localparam int unsigned MEM_DEPTH     = 2 * FRAME_SAMPLES;
  localparam int unsigned ADDR_W        = $clog2(MEM_DEPTH);
  localparam int unsigned IDX_W         = $clog2(FRAME_SAMPLES + 1);
  localparam int unsigned FRAC_W        = 8;
  localparam int unsigned POS_W         = IDX_W + FRAC_W;

  // Field widths
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned VALUE_W = 6;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned STRIDE_W = 8;

  // Levels and register reset
  localparam logic [LEVEL_W-1:0]  MID_LEVEL    = 8'd128;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = 8'd255;
  localparam logic [LEVEL_W-1:0]  LEVEL_MIN    = 8'd0;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 8'd177;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE_BIT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE_DAC = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CAPTURE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_COMMIT    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd4;

  // Buffer b, slot i lives at b*FRAME_SAMPLES + i
  function automatic logic [ADDR_W-1:0] slot_addr(input logic buf_sel,
                                                  input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] base;
    base = buf_sel ? ADDR_W'(FRAME_SAMPLES) : '0;
    return base + ADDR_W'(idx);
  endfunction

endpackage

@@ rtl/core/scanline_audio_pingpong_resampler_top.sv @@
// Top level: ping-pong sample buffer with fractional-rate playback.
//
//  channel | direction | handshake          | beat payload
//  --------+-----------+--------------------+--------------------------------
//  in      | input     | in_valid/in_stall  | in_kind[2:0], in_value[5:0]
//  out     | output    | out_valid/out_stall| out_dac_sample[7:0]
//  cfg     | input     | cfg_valid/cfg_ready| cfg_stride_q8[7:0]
//
// Level writes and captures take effect on acceptance; a tick reads the sample memory
// into rd_data_r, then loads the output register from it in S_LOAD once it is free.
// A commit of a partial frame pads the rest of the frame in S_FILL, one slot a cycle,
// after reading back the last stored sample in S_PAD when fill is nonzero.
// After reset a clearing pass writes 128 to all 2*FRAME_SAMPLES (524) entries,
// one per cycle; in_stall stays high until it is done. cfg is always ready.
// A tick may be taken while the previous result still waits on out_stall; it
// then holds in_stall high until that result leaves.
module scanline_audio_pingpong_resampler_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sapr_pkg::KIND_W-1:0]     in_kind,
  input  logic [sapr_pkg::VALUE_W-1:0]    in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sapr_pkg::LEVEL_W-1:0]    out_dac_sample,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sapr_pkg::STRIDE_W-1:0]   cfg_stride_q8
);
  import sapr_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PAD,
    S_FILL,
    S_LOAD
  } state_t;

  // Sample memory
  logic [LEVEL_W-1:0] mem [MEM_DEPTH];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [LEVEL_W-1:0] mem_wd;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_ra;
  logic [LEVEL_W-1:0] rd_data_r;

  // Control state
  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0]    fill_r, fill_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                write_sel_r, write_sel_nxt;
  logic                play_sel_r, play_sel_nxt;
  logic                ready_r, ready_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic [LEVEL_W-1:0]  pad_r, pad_nxt;
  logic [STRIDE_W-1:0] stride_r, stride_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]  out_data_r, out_data_nxt;

  // Tick path
  logic                in_accept;
  logic                tick_sel;
  logic [POS_W-1:0]    tick_pos;
  logic [IDX_W-1:0]    tick_idx;
  logic [FRAC_W-1:0]   tick_frac;
  logic                out_load;

  assign in_accept      = in_valid && !in_stall;
  assign in_stall       = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_dac_sample = out_data_r;
  assign out_load       = (state_r == S_LOAD) && (!out_valid_r || !out_stall);

  // Swap first if a frame waits, then restart at zero once the integer position reaches the frame end
  always_comb begin
    tick_sel = ready_r ? write_sel_r : play_sel_r;
    tick_pos = ready_r ? '0 : pos_r;
    if (tick_pos[POS_W-1:FRAC_W] >= IDX_W'(FRAME_SAMPLES)) begin
      tick_idx  = '0;
      tick_frac = '0;
    end else begin
      tick_idx  = tick_pos[POS_W-1:FRAC_W];
      tick_frac = tick_pos[FRAC_W-1:0];
    end
  end

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    write_sel_nxt = write_sel_r;
    play_sel_nxt  = play_sel_r;
    ready_nxt     = ready_r;
    level_nxt     = level_r;
    pad_nxt       = pad_r;
    stride_nxt    = (cfg_valid && cfg_ready) ? cfg_stride_q8 : stride_r;
    out_data_nxt  = out_load ? rd_data_r : out_data_r;
    out_valid_nxt = out_load || (out_valid_r && out_stall);
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = MID_LEVEL;
    mem_re        = 1'b0;
    mem_ra        = slot_addr(tick_sel, tick_idx);

    case (state_r)
      // Power-up sweep of the sample memory
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_cnt_r;
        mem_wd      = MID_LEVEL;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(MEM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          case (in_kind)
            KIND_WRITE_BIT: begin
              level_nxt = in_value[0] ? LEVEL_MAX : LEVEL_MIN;
            end
            KIND_WRITE_DAC: begin
              level_nxt = {in_value, in_value[VALUE_W-1:VALUE_W-2]};
            end
            KIND_CAPTURE: begin
              if (fill_r < IDX_W'(FRAME_SAMPLES)) begin
                mem_we   = 1'b1;
                mem_wa   = slot_addr(write_sel_r, fill_r);
                mem_wd   = level_r;
                fill_nxt = fill_r + 1'b1;
              end
            end
            KIND_COMMIT: begin
              if (fill_r >= IDX_W'(FRAME_SAMPLES)) begin
                ready_nxt = 1'b1;
                fill_nxt  = '0;
              end else if (fill_r == '0) begin
                // Empty frame pads with mid level
                pad_nxt   = MID_LEVEL;
                state_nxt = S_FILL;
              end else begin
                // Pad value is the last slot stored in the current write buffer
                mem_re    = 1'b1;
                mem_ra    = slot_addr(write_sel_r, fill_r - 1'b1);
                state_nxt = S_PAD;
              end
            end
            KIND_TICK: begin
              if (ready_r) begin
                play_sel_nxt  = write_sel_r;
                write_sel_nxt = ~write_sel_r;
                ready_nxt     = 1'b0;
              end
              mem_re    = 1'b1;
              pos_nxt   = {tick_idx, tick_frac} + POS_W'(stride_r);
              state_nxt = S_LOAD;
            end
            default: begin
            end
          endcase
        end
      end
      // Latch the read-back pad value
      S_PAD: begin
        pad_nxt   = rd_data_r;
        state_nxt = S_FILL;
      end
      // Pad the rest of the write buffer, one slot a cycle
      S_FILL: begin
        mem_we = 1'b1;
        mem_wa = slot_addr(write_sel_r, fill_r);
        mem_wd = pad_r;
        if (fill_r == IDX_W'(FRAME_SAMPLES - 1)) begin
          fill_nxt  = '0;
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      // Read data is in rd_data_r; wait for the output register
      S_LOAD: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      fill_r      <= '0;
      pos_r       <= '0;
      write_sel_r <= 1'b0;
      play_sel_r  <= 1'b1;
      ready_r     <= 1'b0;
      level_r     <= MID_LEVEL;
      pad_r       <= MID_LEVEL;
      stride_r    <= STRIDE_RESET;
      out_valid_r <= 1'b0;
      out_data_r  <= MID_LEVEL;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      write_sel_r <= write_sel_nxt;
      play_sel_r  <= play_sel_nxt;
      ready_r     <= ready_nxt;
      level_r     <= level_nxt;
      pad_r       <= pad_nxt;
      stride_r    <= stride_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // Sample memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Write and play buffers are always distinct
  a_sel_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    write_sel_r != play_sel_r)
    else $error("write and play buffer selects collide");

  // Stored position never passes the frame end
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r[POS_W-1:FRAC_W] <= IDX_W'(FRAME_SAMPLES))
    else $error("play position beyond frame");

  // Padding only runs inside the frame
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> fill_r < IDX_W'(FRAME_SAMPLES))
    else $error("padding past frame end");

  // An accepted tick always leads into the load phase
  a_load_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_kind == KIND_TICK |=> state_r == S_LOAD)
    else $error("tick did not start a memory read");

endmodule
